### hdl/nns_pkg.sv
package nns_pkg;

  // default source frame geometry
  localparam int DEF_ROW_PIXELS = 512;
  localparam int DEF_ROWS       = 512;

  // field and register widths
  localparam int POS_W    = 12;
  localparam int STEP_W   = 25;
  localparam int SIZE_W   = 10;
  localparam int PIXEL_W  = 32;
  localparam int RGB_W    = 24;
  localparam int PROD_W   = POS_W + STEP_W;
  localparam int FRAC_W   = 16;
  localparam int IDX_RAW_W = PROD_W - FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STEP_W;
  localparam int S_DATA_W   = 56;

  // register reset values
  localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = SIZE_W'(240);
  localparam logic [STEP_W-1:0] RST_STEP       = STEP_W'(65536);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_X_STEP     = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_OUT_FORMAT = 3'd4
  } cfg_reg_t;

  // output pixel formats
  typedef enum logic {
    FMT_RGBA8888 = 1'b0,
    FMT_RGB565   = 1'b1
  } out_format_t;

  // item kinds carried on tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

endpackage

### hdl/nns_coord_map.sv
module nns_coord_map #(
  parameter int LIMIT = nns_pkg::DEF_ROW_PIXELS,
  parameter int IDX_W = $clog2(LIMIT)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [nns_pkg::POS_W-1:0]   pos,
  input  logic [nns_pkg::STEP_W-1:0]  step,
  input  logic [nns_pkg::SIZE_W-1:0]  size,
  output logic [IDX_W-1:0]            idx
);
  import nns_pkg::*;

  logic [PROD_W-1:0]    prod;
  logic [IDX_RAW_W-1:0] raw;
  logic [IDX_RAW_W-1:0] size_ext;
  logic [IDX_RAW_W-1:0] lim_ext;
  logic [IDX_RAW_W-1:0] eff;
  logic [IDX_RAW_W-1:0] clamped;

  // stage a: scaled position in q21.16
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(pos) * PROD_W'(step);
    end
  end

  // effective size: zero acts as one, capped at the store limit
  assign size_ext = IDX_RAW_W'(size);
  assign lim_ext  = IDX_RAW_W'(LIMIT);
  always_comb begin
    if (size == '0) begin
      eff = IDX_RAW_W'(1);
    end else if (size_ext > lim_ext) begin
      eff = lim_ext;
    end else begin
      eff = size_ext;
    end
  end

  // stage b: drop the fraction and saturate to the last pixel
  assign raw     = prod[PROD_W-1:FRAC_W];
  assign clamped = (raw >= eff) ? (eff - IDX_RAW_W'(1)) : raw;

  always_ff @(posedge clk) begin
    if (en) begin
      idx <= clamped[IDX_W-1:0];
    end
  end

endmodule

### hdl/nns_frame_store.sv
module nns_frame_store #(
  parameter int DEPTH = nns_pkg::DEF_ROW_PIXELS * nns_pkg::DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [nns_pkg::RGB_W-1:0]  wdata,
  output logic [nns_pkg::RGB_W-1:0]  rdata
);
  import nns_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];

  // single port, registered read, held while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

### hdl/nearest_neighbor_scaler_core.sv
// Nearest-neighbour scaler. Write items (tuser 0) load one 24-bit pixel of the
// source frame; fetch items (tuser 1) name a destination pixel and return the
// source pixel at floor(x*x_step), floor(y*y_step) in Q9.16, each clamped to
// the effective source size less one, as RGBA8888 (alpha 0xFF) or RGB565. The
// pipeline takes one item per clock while the output is not back-pressured.
// Writes and fetches pass the single-port frame store in order, so a fetch
// always sees every earlier write. Back-pressure on the output freezes the
// whole pipeline. The frame store has no reset: a fetch of a pixel never
// written returns an undefined value. The user must write registers only while
// the pipeline is empty; the block itself does not enforce this.
module nearest_neighbor_scaler_core #(
  parameter int SRC_ROW_PIXELS = nns_pkg::DEF_ROW_PIXELS,
  parameter int SRC_ROWS       = nns_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [nns_pkg::S_DATA_W-1:0]    s_tdata,   // x[11:0], y[23:12], pixel[47:24]
  input  logic                            s_tuser,   // op[0]
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nns_pkg::PIXEL_W-1:0]     m_tdata,   // pixel_out[31:0]
  // register writes
  input  logic                            cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nns_pkg::*;

  localparam int CW    = $clog2(SRC_ROW_PIXELS);
  localparam int RW    = $clog2(SRC_ROWS);
  localparam int DEPTH = SRC_ROW_PIXELS * SRC_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = POS_W + 1;

  // registers
  logic [SIZE_W-1:0] src_width;
  logic [SIZE_W-1:0] src_height;
  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;
  out_format_t       out_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_WIDTH;
      src_height <= RST_SRC_HEIGHT;
      x_step     <= RST_STEP;
      y_step     <= RST_STEP;
      out_format <= FMT_RGBA8888;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SIZE_W-1:0];
        REG_X_STEP:     x_step     <= cfg_data;
        REG_Y_STEP:     y_step     <= cfg_data;
        REG_OUT_FORMAT: out_format <= out_format_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being taken
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: input register
  logic             v1;
  op_t              op1;
  logic [POS_W-1:0] x1, y1;
  logic [RGB_W-1:0] pix1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= op_t'(s_tuser);
      x1   <= s_tdata[POS_W-1:0];
      y1   <= s_tdata[2*POS_W-1:POS_W];
      pix1 <= s_tdata[2*POS_W+RGB_W-1:2*POS_W];
    end
  end

  // stages 2 and 3: coordinate mapping, one multiply per axis
  logic [CW-1:0] sx3;
  logic [RW-1:0] sy3;

  nns_coord_map #(.LIMIT(SRC_ROW_PIXELS), .IDX_W(CW)) u_map_x (
    .clk  (clk),
    .en   (adv),
    .pos  (x1),
    .step (x_step),
    .size (src_width),
    .idx  (sx3)
  );

  nns_coord_map #(.LIMIT(SRC_ROWS), .IDX_W(RW)) u_map_y (
    .clk  (clk),
    .en   (adv),
    .pos  (y1),
    .step (y_step),
    .size (src_height),
    .idx  (sy3)
  );

  // write items travel alongside the mapping stages
  logic             v2, v3;
  op_t              op2, op3;
  logic             we2, we3;
  logic [POS_W-1:0] wx2, wy2;
  logic [CW-1:0]    wx3;
  logic [RW-1:0]    wy3;
  logic [RGB_W-1:0] pix2, pix3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2  <= op1;
      we2  <= (CMP_W'(x1) < CMP_W'(SRC_ROW_PIXELS)) && (CMP_W'(y1) < CMP_W'(SRC_ROWS));
      wx2  <= x1;
      wy2  <= y1;
      pix2 <= pix1;
      op3  <= op2;
      we3  <= we2;
      wx3  <= wx2[CW-1:0];
      wy3  <= wy2[RW-1:0];
      pix3 <= pix2;
    end
  end

  // stage 4: linear frame address
  logic             v4;
  op_t              op4;
  logic             we4;
  logic [AW-1:0]    addr4;
  logic [RGB_W-1:0] pix4;
  logic [CW-1:0]    col_sel;
  logic [RW-1:0]    row_sel;

  assign col_sel = (op3 == OP_FETCH) ? sx3 : wx3;
  assign row_sel = (op3 == OP_FETCH) ? sy3 : wy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op4   <= op3;
      we4   <= we3;
      addr4 <= AW'(row_sel) * AW'(SRC_ROW_PIXELS) + AW'(col_sel);
      pix4  <= pix3;
    end
  end

  // stage 5: frame store access
  logic             v5;
  op_t              op5;
  logic             mem_we;
  logic [RGB_W-1:0] rd5;

  assign mem_we = v4 && (op4 == OP_WRITE) && we4;

  nns_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .en    (adv),
    .we    (mem_we),
    .addr  (addr4),
    .wdata (pix4),
    .rdata (rd5)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op5 <= op4;
    end
  end

  // stage 6: pixel formatting into the output register
  logic [7:0]         r5, g5, b5;
  logic [PIXEL_W-1:0] fmt5;

  assign r5 = rd5[23:16];
  assign g5 = rd5[15:8];
  assign b5 = rd5[7:0];

  always_comb begin
    case (out_format)
      FMT_RGB565: fmt5 = {16'h0000, r5[7:3], g5[7:2], b5[7:3]};
      default:    fmt5 = {8'hFF, b5, g5, r5};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v5 && (op5 == OP_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= fmt5;
    end
  end

  // a result appears only for a fetch leaving the store stage
  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v5 && (op5 == OP_FETCH)))
    else $error("result without a fetch in the store stage");

  // a stall freezes every pipeline valid bit
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3, v4, v5}))
    else $error("pipeline moved during a stall");

  // a fetch leaving the store stage is never dropped
  a_fetch_delivered: assert property (@(posedge clk) disable iff (rst)
    (adv && v5 && (op5 == OP_FETCH)) |=> m_tvalid)
    else $error("fetch lost before the output register");

endmodule
